// File: hw/rtl/pct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

   localparam int POS_BITS  = 20;
   localparam int LINE_BITS = 16;

   localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // scan modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_UNKNOWN = 3'd2;
   localparam logic [2:0] MODE_SQ      = 3'd3;
   localparam logic [2:0] MODE_DQ      = 3'd4;

   // token kinds
   localparam logic [3:0] KIND_END       = 4'd0;
   localparam logic [3:0] KIND_SEMI      = 4'd1;
   localparam logic [3:0] KIND_LPAR      = 4'd2;
   localparam logic [3:0] KIND_RPAR      = 4'd3;
   localparam logic [3:0] KIND_STRING    = 4'd4;
   localparam logic [3:0] KIND_IDENT     = 4'd5;
   localparam logic [3:0] KIND_ALGORITHM = 4'd6;
   localparam logic [3:0] KIND_BEGIN     = 4'd7;
   localparam logic [3:0] KIND_END_KW    = 4'd8;
   localparam logic [3:0] KIND_WRITE     = 4'd9;
   localparam logic [3:0] KIND_ERROR     = 4'd10;
   localparam logic [3:0] KIND_UNKNOWN   = 4'd11;

   // characters
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NL         = 8'h0A;
   localparam logic [7:0] CH_VT         = 8'h0B;
   localparam logic [7:0] CH_FF         = 8'h0C;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_LPAR       = 8'h28;
   localparam logic [7:0] CH_RPAR       = 8'h29;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

   // keywords, left aligned, first character in the top byte
   localparam int KW_COUNT = 4;
   localparam int KW_MAX   = 9;
   localparam logic [KW_COUNT-1:0] KW_ALL = {KW_COUNT{1'b1}};
   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
      "Algorithm", {"Begin", 32'h0}, {"End", 48'h0}, {"Write", 32'h0}};
   localparam int KW_LEN [KW_COUNT] = '{9, 5, 3, 5};
   localparam logic [3:0] KW_KIND [KW_COUNT] = '{
      KIND_ALGORITHM, KIND_BEGIN, KIND_END_KW, KIND_WRITE};

   typedef struct packed {
      logic [3:0]           kind;
      logic [LINE_BITS-1:0] line_no;
      logic [POS_BITS-1:0]  start;
      logic [POS_BITS-1:0]  len;
   } token_type;

   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_VT, CH_FF};
   endfunction

   function automatic logic is_term(input logic [7:0] c);
      return is_ws(c) || (c inside {CH_NUL, CH_SEMI, CH_LPAR, CH_RPAR, CH_SQUOTE, CH_DQUOTE});
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDERSCORE};
   endfunction

   // clear the flag of every keyword that does not have c at offset idx
   function automatic logic [KW_COUNT-1:0] kw_update(input logic [KW_COUNT-1:0] hits,
                                                     input logic [POS_BITS-1:0] idx,
                                                     input logic [7:0]          c);
      logic [KW_COUNT-1:0] res;
      logic                match;
      int                  sel;
      res = hits;
      for (int k = 0; k < KW_COUNT; k++) begin
         match = 1'b0;
         if (idx < POS_BITS'(KW_LEN[k])) begin
            sel   = KW_MAX - 1 - int'(idx[3:0]);
            match = (KW_TEXT[k][sel*8 +: 8] == c);
         end
         if (!match) begin
            res[k] = 1'b0;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pct_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface pct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [3:0]                    kind;
   logic [pct_pkg::LINE_BITS-1:0] line_no;
   logic [pct_pkg::POS_BITS-1:0]  lexeme_start;
   logic [pct_pkg::POS_BITS-1:0]  lexeme_len;
   logic                          last_of_run;
   modport source (output valid, output kind, output line_no, output lexeme_start,
                   output lexeme_len, output last_of_run, input ready);
   modport sink (input valid, input kind, input line_no, input lexeme_start,
                 input lexeme_len, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pct_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pct_front (
   input  wire logic           clock,
   input  wire logic           reset,
   pct_req_if.sink             req,
   input  wire logic           full,
   output pct_pkg::entry_type  push_entry,
   output logic                push
);

   logic [2:0]                          mode_ff, mode_in;
   logic [pct_pkg::POS_BITS-1:0]        pos_ff, pos_in;
   logic [pct_pkg::LINE_BITS-1:0]       line_ff, line_in;
   logic [pct_pkg::POS_BITS-1:0]        tb_ff, tb_in;
   logic [pct_pkg::KW_COUNT-1:0]        hits_ff, hits_in;

   logic                                accept;
   logic [1:0]                          n_tok;
   pct_pkg::token_type                  tok0, tok1, idle_tok;
   logic                                do_idle, idle_valid;
   logic [pct_pkg::POS_BITS-1:0]        len, pos_adv;
   logic [3:0]                          run_kind;

   assign req.ready = !full;
   assign accept    = req.valid && !full;

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      line_in    = line_ff;
      tb_in      = tb_ff;
      hits_in    = hits_ff;
      n_tok      = 2'd0;
      tok0       = '0;
      tok1       = '0;
      do_idle    = 1'b0;
      idle_valid = 1'b0;
      idle_tok   = '0;
      run_kind   = pct_pkg::KIND_UNKNOWN;
      len        = pos_ff - tb_ff;
      pos_adv    = (pos_ff != pct_pkg::POS_MAX) ? pos_ff + 1'b1 : pos_ff;

      case (mode_ff)
         pct_pkg::MODE_IDENT, pct_pkg::MODE_UNKNOWN: begin
            if (pct_pkg::is_term(req.ch)) begin
               if (mode_ff == pct_pkg::MODE_IDENT) begin
                  run_kind = pct_pkg::KIND_IDENT;
                  for (int k = 0; k < pct_pkg::KW_COUNT; k++) begin
                     if (hits_ff[k] && len == pct_pkg::POS_BITS'(pct_pkg::KW_LEN[k])) begin
                        run_kind = pct_pkg::KW_KIND[k];
                     end
                  end
               end
               tok0.kind    = run_kind;
               tok0.line_no = line_ff;
               tok0.start   = tb_ff;
               tok0.len     = len;
               n_tok        = 2'd1;
               mode_in      = pct_pkg::MODE_IDLE;
               do_idle      = 1'b1;
            end else begin
               if (mode_ff == pct_pkg::MODE_IDENT) begin
                  hits_in = pct_pkg::kw_update(hits_ff, len, req.ch);
               end
               pos_in = pos_adv;
            end
         end
         pct_pkg::MODE_SQ, pct_pkg::MODE_DQ: begin
            if (req.ch == pct_pkg::CH_NUL) begin
               tok0.kind    = pct_pkg::KIND_ERROR;
               tok0.line_no = line_ff;
               tok0.start   = tb_ff;
               tok0.len     = len;
               tok1.kind    = pct_pkg::KIND_END;
               tok1.line_no = line_ff;
               tok1.start   = pos_ff;
               tok1.len     = '0;
               n_tok        = 2'd2;
               mode_in      = pct_pkg::MODE_IDLE;
               pos_in       = '0;
               line_in      = pct_pkg::LINE_ONE;
               tb_in        = '0;
               hits_in      = pct_pkg::KW_ALL;
            end else if ((mode_ff == pct_pkg::MODE_SQ && req.ch == pct_pkg::CH_SQUOTE) ||
                         (mode_ff == pct_pkg::MODE_DQ && req.ch == pct_pkg::CH_DQUOTE)) begin
               tok0.kind    = pct_pkg::KIND_STRING;
               tok0.line_no = line_ff;
               tok0.start   = tb_ff;
               tok0.len     = len;
               n_tok        = 2'd1;
               mode_in      = pct_pkg::MODE_IDLE;
               pos_in       = pos_adv;
            end else begin
               pos_in = pos_adv;
            end
         end
         default: begin
            mode_in = pct_pkg::MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         idle_tok.line_no = line_ff;
         idle_tok.start   = pos_ff;
         idle_tok.len     = pct_pkg::POS_BITS'(1);
         if (req.ch == pct_pkg::CH_NUL) begin
            idle_valid     = 1'b1;
            idle_tok.kind  = pct_pkg::KIND_END;
            idle_tok.len   = '0;
            mode_in        = pct_pkg::MODE_IDLE;
            pos_in         = '0;
            line_in        = pct_pkg::LINE_ONE;
            tb_in          = '0;
            hits_in        = pct_pkg::KW_ALL;
         end else begin
            pos_in = pos_adv;
            if (pct_pkg::is_ws(req.ch)) begin
               if (req.ch == pct_pkg::CH_NL && line_ff != pct_pkg::LINE_MAX) begin
                  line_in = line_ff + 1'b1;
               end
            end else if (req.ch == pct_pkg::CH_SEMI) begin
               idle_valid    = 1'b1;
               idle_tok.kind = pct_pkg::KIND_SEMI;
            end else if (req.ch == pct_pkg::CH_LPAR) begin
               idle_valid    = 1'b1;
               idle_tok.kind = pct_pkg::KIND_LPAR;
            end else if (req.ch == pct_pkg::CH_RPAR) begin
               idle_valid    = 1'b1;
               idle_tok.kind = pct_pkg::KIND_RPAR;
            end else if (req.ch == pct_pkg::CH_SQUOTE || req.ch == pct_pkg::CH_DQUOTE) begin
               mode_in = (req.ch == pct_pkg::CH_SQUOTE) ? pct_pkg::MODE_SQ : pct_pkg::MODE_DQ;
               tb_in   = pos_adv;
            end else if (pct_pkg::is_ident_start(req.ch)) begin
               mode_in = pct_pkg::MODE_IDENT;
               tb_in   = pos_ff;
               hits_in = pct_pkg::kw_update(pct_pkg::KW_ALL, '0, req.ch);
            end else begin
               mode_in = pct_pkg::MODE_UNKNOWN;
               tb_in   = pos_ff;
            end
         end
         if (idle_valid) begin
            if (n_tok == 2'd0) begin
               tok0 = idle_tok;
            end else begin
               tok1 = idle_tok;
            end
            n_tok = n_tok + 2'd1;
         end
      end
   end

   assign push            = accept && (n_tok != 2'd0);
   assign push_entry.two  = (n_tok == 2'd2);
   assign push_entry.tok0 = tok0;
   assign push_entry.tok1 = tok1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pct_pkg::MODE_IDLE;
         pos_ff  <= '0;
         line_ff <= pct_pkg::LINE_ONE;
         tb_ff   <= '0;
         hits_ff <= pct_pkg::KW_ALL;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         line_ff <= line_in;
         tb_ff   <= tb_in;
         hits_ff <= hits_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pct_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pct_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire pct_pkg::entry_type   push_entry,
   input  wire logic                 pop,
   output pct_pkg::entry_type        head,
   output logic                      empty,
   output logic                      full
);

   pct_pkg::entry_type               entries [pct_pkg::QUEUE_DEPTH];
   logic [pct_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pct_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pct_pkg::QPTR_BITS:0]      count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (pct_pkg::QPTR_BITS+1)'(pct_pkg::QUEUE_DEPTH));
   assign head  = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff[pct_pkg::QPTR_BITS-1:0] == wr_ptr_ff - rd_ptr_ff))
      else $error("queue count disagrees with pointers");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pct_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pct_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pct_pkg::entry_type   head,
   input  wire logic                 empty,
   output logic                      pop,
   pct_rsp_if.source                 rsp
);

   logic                 out_valid_ff, out_valid_in;
   pct_pkg::token_type   out_tok_ff, out_tok_in;
   logic                 out_last_ff, out_last_in;
   logic                 phase_ff, phase_in;
   logic                 load;

   assign load = !empty && (!out_valid_ff || rsp.ready);

   always_comb begin
      out_tok_in   = out_tok_ff;
      out_last_in  = out_last_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (load) begin
         out_valid_in = 1'b1;
         if (head.two && !phase_ff) begin
            out_tok_in  = head.tok0;
            out_last_in = 1'b0;
            phase_in    = 1'b1;
         end else begin
            out_tok_in  = phase_ff ? head.tok1 : head.tok0;
            out_last_in = 1'b1;
            phase_in    = 1'b0;
            pop         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff  <= out_tok_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_tok_ff.kind;
   assign rsp.line_no      = out_tok_ff.line_no;
   assign rsp.lexeme_start = out_tok_ff.start;
   assign rsp.lexeme_len   = out_tok_ff.len;
   assign rsp.last_of_run  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_phase_holds_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!empty && head.two))
      else $error("second token pending without a two-token entry");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> phase_ff)
      else $error("first of two tokens shown without pending second");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pseudo_code_tokenizer_top.sv
// Byte-serial tokenizer: one source byte per transaction on req_chan (0 ends the text and
// resets the scanner), tokens out on rsp_chan with kind, line, start offset, length and a
// flag on the last token a byte produced. The front scanner takes a byte every cycle while
// the queue is not full and writes the zero, one or two tokens it causes as one entry into
// a four-entry queue; the back end drains one token per cycle, unless rsp_chan stalls, into
// an output register. A byte's first token passes the queue entry and the output register
// before it shows on rsp_chan, its second token after it; req_chan stalls only when
// the queue is full; sustained, one byte per cycle, bounded by one token per cycle out.
`timescale 1ns / 1ps
`default_nettype none

module pseudo_code_tokenizer_top (
   input  wire logic  clock,
   input  wire logic  reset,
   pct_req_if.sink    req_chan,
   pct_rsp_if.source  rsp_chan
);

   pct_pkg::entry_type push_entry;
   pct_pkg::entry_type head;
   logic               push;
   logic               pop;
   logic               empty;
   logic               full;

   pct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .full       (full),
      .push_entry (push_entry),
      .push       (push)
   );

   pct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   pct_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/pseudo_code_tokenizer_top_tb.sv
`timescale 1ns / 1ps

module pseudo_code_tokenizer_top_tb;

   typedef struct packed {
      logic [3:0]                    kind;
      logic [pct_pkg::LINE_BITS-1:0] line_no;
      logic [pct_pkg::POS_BITS-1:0]  start;
      logic [pct_pkg::POS_BITS-1:0]  len;
      logic                          last;
   } exp_token_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          typed;
      logic          two;
      exp_token_type tok0;
      exp_token_type tok1;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pct_req_if req_bus ();
   pct_rsp_if rsp_bus ();

   pseudo_code_tokenizer_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scanner state as seen by the checker
   logic [2:0]                    scan_mode_q;
   logic [pct_pkg::POS_BITS-1:0]  scan_pos;
   logic [pct_pkg::LINE_BITS-1:0] scan_line;
   logic [pct_pkg::POS_BITS-1:0]  scan_begin;
   logic [3:0]                    kw_live;
   exp_token_type                 tok_out [2];
   int                            tok_cnt;

   exp_token_type expected_tokens [$];
   exp_token_type want;
   row_type       offer_row;
   row_type       dir_rows [26];
   int            fail_count = 0;
   int            byte_count = 0;
   int            sender_calm = 0;
   int            stall_left = 0;
   int            calm_left = 0;
   int            hold_cycles = 0;
   int            drain_wait = 0;
   bit            quiet_tail = 1'b0;
   bit            hold_req = 1'b0;
   bit            hold_done = 1'b0;

   function automatic bit is_blank(input logic [7:0] c);
      return c == pct_pkg::CH_SPACE || (c >= pct_pkg::CH_TAB && c <= pct_pkg::CH_CR);
   endfunction

   function automatic bit is_delim(input logic [7:0] c);
      return c == pct_pkg::CH_NUL || is_blank(c) || c == pct_pkg::CH_SEMI ||
             c == pct_pkg::CH_LPAR || c == pct_pkg::CH_RPAR ||
             c == pct_pkg::CH_SQUOTE || c == pct_pkg::CH_DQUOTE;
   endfunction

   function automatic bit is_word_start(input logic [7:0] c);
      return (c >= pct_pkg::CH_UPPER_A && c <= pct_pkg::CH_UPPER_Z) ||
             (c >= pct_pkg::CH_LOWER_A && c <= pct_pkg::CH_LOWER_Z) ||
             c == pct_pkg::CH_UNDERSCORE;
   endfunction

   function automatic string keyword(input int k);
      case (k)
         0: return "Algorithm";
         1: return "Begin";
         2: return "End";
         default: return "Write";
      endcase
   endfunction

   function automatic logic [3:0] kw_step(input logic [3:0] live,
                                          input logic [pct_pkg::POS_BITS-1:0] idx,
                                          input logic [7:0] c);
      string      w;
      logic [3:0] res;
      res = live;
      for (int k = 0; k < 4; k++) begin
         w = keyword(k);
         if (idx >= w.len() || w[idx] != c) res[k] = 1'b0;
      end
      return res;
   endfunction

   task automatic lexer_clear();
      scan_mode_q = pct_pkg::MODE_IDLE;
      scan_pos    = '0;
      scan_line   = pct_pkg::LINE_ONE;
      scan_begin  = '0;
      kw_live     = pct_pkg::KW_ALL;
   endtask

   task automatic step_pos();
      if (scan_pos != pct_pkg::POS_MAX) scan_pos = scan_pos + 1'b1;
   endtask

   task automatic lex_emit(input logic [3:0] k, input logic [pct_pkg::POS_BITS-1:0] s,
                           input logic [pct_pkg::POS_BITS-1:0] n);
      tok_out[tok_cnt] = {k, scan_line, s, n, 1'b0};
      tok_cnt++;
   endtask

   task automatic idle_lex(input logic [7:0] c);
      if (c == pct_pkg::CH_NUL) begin
         lex_emit(pct_pkg::KIND_END, scan_pos, '0);
         lexer_clear();
      end else begin
         if (is_blank(c)) begin
            if (c == pct_pkg::CH_NL && scan_line != pct_pkg::LINE_MAX) begin
               scan_line = scan_line + 1'b1;
            end
         end else if (c == pct_pkg::CH_SEMI) begin
            lex_emit(pct_pkg::KIND_SEMI, scan_pos, pct_pkg::POS_BITS'(1));
         end else if (c == pct_pkg::CH_LPAR) begin
            lex_emit(pct_pkg::KIND_LPAR, scan_pos, pct_pkg::POS_BITS'(1));
         end else if (c == pct_pkg::CH_RPAR) begin
            lex_emit(pct_pkg::KIND_RPAR, scan_pos, pct_pkg::POS_BITS'(1));
         end else if (c == pct_pkg::CH_SQUOTE || c == pct_pkg::CH_DQUOTE) begin
            scan_mode_q = (c == pct_pkg::CH_SQUOTE) ? pct_pkg::MODE_SQ : pct_pkg::MODE_DQ;
            scan_begin  = (scan_pos != pct_pkg::POS_MAX) ? scan_pos + 1'b1 : scan_pos;
         end else if (is_word_start(c)) begin
            scan_mode_q = pct_pkg::MODE_IDENT;
            scan_begin  = scan_pos;
            kw_live     = kw_step(pct_pkg::KW_ALL, '0, c);
         end else begin
            scan_mode_q = pct_pkg::MODE_UNKNOWN;
            scan_begin  = scan_pos;
         end
         step_pos();
      end
   endtask

   task automatic lex_byte(input logic [7:0] c);
      logic [pct_pkg::POS_BITS-1:0] run_len;
      logic [3:0]                   k;
      string                        w;
      run_len = scan_pos - scan_begin;
      tok_cnt = 0;
      case (scan_mode_q)
         pct_pkg::MODE_IDENT, pct_pkg::MODE_UNKNOWN: begin
            if (is_delim(c)) begin
               k = pct_pkg::KIND_UNKNOWN;
               if (scan_mode_q == pct_pkg::MODE_IDENT) begin
                  k = pct_pkg::KIND_IDENT;
                  for (int i = 0; i < 4; i++) begin
                     w = keyword(i);
                     if (kw_live[i] && run_len == w.len()) begin
                        k = pct_pkg::KIND_ALGORITHM + 4'(i);
                     end
                  end
               end
               lex_emit(k, scan_begin, run_len);
               scan_mode_q = pct_pkg::MODE_IDLE;
               idle_lex(c);
            end else begin
               if (scan_mode_q == pct_pkg::MODE_IDENT) kw_live = kw_step(kw_live, run_len, c);
               step_pos();
            end
         end
         pct_pkg::MODE_SQ, pct_pkg::MODE_DQ: begin
            if (c == pct_pkg::CH_NUL) begin
               lex_emit(pct_pkg::KIND_ERROR, scan_begin, run_len);
               lex_emit(pct_pkg::KIND_END, scan_pos, '0);
               lexer_clear();
            end else if ((scan_mode_q == pct_pkg::MODE_SQ && c == pct_pkg::CH_SQUOTE) ||
                         (scan_mode_q == pct_pkg::MODE_DQ && c == pct_pkg::CH_DQUOTE)) begin
               lex_emit(pct_pkg::KIND_STRING, scan_begin, run_len);
               scan_mode_q = pct_pkg::MODE_IDLE;
               step_pos();
            end else begin
               step_pos();
            end
         end
         default: idle_lex(c);
      endcase
      if (tok_cnt > 0) tok_out[tok_cnt-1].last = 1'b1;
   endtask

   // byte accepted: advance the scanner and queue what it should emit
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         lex_byte(req_bus.ch);
         if (offer_row.typed) begin
            expected_tokens.push_back(offer_row.tok0);
            if (offer_row.two) expected_tokens.push_back(offer_row.tok1);
         end else begin
            for (int i = 0; i < tok_cnt; i++) expected_tokens.push_back(tok_out[i]);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: expected no token, got kind %0d line %0d start %0d len %0d last %0d",
                     $time, rsp_bus.kind, rsp_bus.line_no, rsp_bus.lexeme_start,
                     rsp_bus.lexeme_len, rsp_bus.last_of_run);
            fail_count++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_bus.kind !== want.kind || rsp_bus.line_no !== want.line_no ||
                rsp_bus.lexeme_start !== want.start || rsp_bus.lexeme_len !== want.len ||
                rsp_bus.last_of_run !== want.last) begin
               $display("%0t: expected kind %0d line %0d start %0d len %0d last %0d, %s",
                        $time, want.kind, want.line_no, want.start, want.len, want.last,
                        "got:");
               $display("%0t:      got kind %0d line %0d start %0d len %0d last %0d",
                        $time, rsp_bus.kind, rsp_bus.line_no, rsp_bus.lexeme_start,
                        rsp_bus.lexeme_len, rsp_bus.last_of_run);
               fail_count++;
            end
         end
      end
   end

   function automatic exp_token_type tk(input logic [3:0] k, input int l, input int s,
                                        input int n, input bit last);
      return {k, pct_pkg::LINE_BITS'(l), pct_pkg::POS_BITS'(s), pct_pkg::POS_BITS'(n), last};
   endfunction

   function automatic row_type plain(input logic [7:0] c);
      row_type r;
      r = '0;
      r.ch = c;
      return r;
   endfunction

   function automatic row_type fixed(input logic [7:0] c, input exp_token_type t0,
                                     input bit two, input exp_token_type t1);
      return {c, 1'b1, two, t0, t1};
   endfunction

   task automatic offer(input row_type row);
      if (!quiet_tail && !(hold_req && !hold_done) && sender_calm == 0 &&
          $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      if (sender_calm > 0) sender_calm--;
      else if ($urandom_range(0, 19) == 0) sender_calm = $urandom_range(10, 40);
      offer_row     = row;
      req_bus.ch    = row.ch;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put(input logic [7:0] c);
      offer(plain(c));
      byte_count++;
   endtask

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(pct_pkg::CH_UPPER_A, pct_pkg::CH_UPPER_Z));
         1: return 8'($urandom_range(pct_pkg::CH_LOWER_A, pct_pkg::CH_LOWER_Z));
         2: return 8'($urandom_range(8'h30, 8'h39));
         default: return pct_pkg::CH_UNDERSCORE;
      endcase
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return pct_pkg::CH_SPACE;
         1: return pct_pkg::CH_NL;
         default: return 8'($urandom_range(pct_pkg::CH_TAB, pct_pkg::CH_CR));
      endcase
   endfunction

   function automatic logic [7:0] sep_byte();
      case ($urandom_range(0, 11))
         0: return pct_pkg::CH_SEMI;
         1: return pct_pkg::CH_LPAR;
         2: return pct_pkg::CH_RPAR;
         3: return pct_pkg::CH_NUL;
         4: return ($urandom_range(0, 1) == 0) ? pct_pkg::CH_SQUOTE : pct_pkg::CH_DQUOTE;
         default: return blank_byte();
      endcase
   endfunction

   task automatic put_fragment();
      int         pick;
      int         n;
      string      w;
      logic [7:0] c;
      logic [7:0] q;
      pick = $urandom_range(0, 19);
      if (pick < 6) begin
         // keyword, now and then truncated, recased or extended
         w = keyword($urandom_range(0, 3));
         n = w.len();
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
         for (int i = 0; i < n; i++) begin
            c = w[i];
            if ($urandom_range(0, 11) == 0) c = c ^ 8'h20;
            put(c);
         end
         if ($urandom_range(0, 5) == 0) put(word_char());
         put(sep_byte());
      end else if (pick < 9) begin
         do c = word_char(); while (!is_word_start(c));
         put(c);
         repeat ($urandom_range(0, 10)) put(word_char());
         put(sep_byte());
      end else if (pick < 12) begin
         q = ($urandom_range(0, 1) == 0) ? pct_pkg::CH_SQUOTE : pct_pkg::CH_DQUOTE;
         put(q);
         repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(0, 5) == 0) c = pct_pkg::CH_NL;
            else do c = 8'($urandom_range(1, 255)); while (c == q);
            put(c);
         end
         put(($urandom_range(0, 7) == 0) ? pct_pkg::CH_NUL : q);
      end else if (pick < 14) begin
         do c = 8'($urandom_range(1, 255)); while (is_delim(c) || is_word_start(c));
         put(c);
         repeat ($urandom_range(0, 5)) begin
            do c = 8'($urandom_range(1, 255)); while (is_delim(c));
            put(c);
         end
         put(sep_byte());
      end else if (pick < 16) begin
         case ($urandom_range(0, 2))
            0: put(pct_pkg::CH_SEMI);
            1: put(pct_pkg::CH_LPAR);
            default: put(pct_pkg::CH_RPAR);
         endcase
      end else if (pick < 18) begin
         repeat ($urandom_range(1, 4)) put(blank_byte());
      end else if (pick == 18) begin
         put(pct_pkg::CH_NUL);
      end else begin
         repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            // long hold-off so the block backs up and stalls its input
            rsp_bus.ready = 1'b0;
            for (hold_cycles = 0; hold_cycles < 60; hold_cycles++) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (quiet_tail) begin
               rsp_bus.ready = 1'b1;
            end else if (stall_left > 0) begin
               rsp_bus.ready = 1'b0;
               stall_left--;
            end else if (calm_left > 0) begin
               rsp_bus.ready = 1'b1;
               calm_left--;
            end else begin
               case ($urandom_range(0, 15))
                  0, 1: begin
                     rsp_bus.ready = 1'b0;
                     stall_left = $urandom_range(1, 9) - 1;
                  end
                  2: begin
                     rsp_bus.ready = 1'b1;
                     calm_left = $urandom_range(20, 80);
                  end
                  default: rsp_bus.ready = 1'b1;
               endcase
            end
            @(negedge clock);
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.ch    = pct_pkg::CH_NUL;
      offer_row     = '0;
      lexer_clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      dir_rows = '{
         fixed(pct_pkg::CH_NUL, tk(pct_pkg::KIND_END, 1, 0, 0, 1), 1'b0, '0),
         fixed(pct_pkg::CH_SEMI, tk(pct_pkg::KIND_SEMI, 1, 0, 1, 1), 1'b0, '0),
         fixed(pct_pkg::CH_LPAR, tk(pct_pkg::KIND_LPAR, 1, 1, 1, 1), 1'b0, '0),
         fixed(pct_pkg::CH_RPAR, tk(pct_pkg::KIND_RPAR, 1, 2, 1, 1), 1'b0, '0),
         plain(pct_pkg::CH_NL), plain("E"), plain("n"), plain("d"), plain(pct_pkg::CH_SEMI),
         plain(pct_pkg::CH_DQUOTE), plain(pct_pkg::CH_NL), plain(8'h80),
         plain(pct_pkg::CH_DQUOTE),
         plain(pct_pkg::CH_UNDERSCORE), plain("9"), plain(pct_pkg::CH_NUL),
         plain(pct_pkg::CH_SQUOTE), plain("a"),
         fixed(pct_pkg::CH_NUL, tk(pct_pkg::KIND_ERROR, 1, 1, 1, 0), 1'b1,
               tk(pct_pkg::KIND_END, 1, 2, 0, 1)),
         plain("#"), plain(8'hFF), plain(pct_pkg::CH_TAB),
         plain(pct_pkg::CH_CR), plain(pct_pkg::CH_VT), plain(pct_pkg::CH_FF),
         plain(pct_pkg::CH_NUL)
      };
      foreach (dir_rows[i]) offer(dir_rows[i]);

      byte_count = 0;
      while (byte_count < 1075) begin
         if (byte_count >= 400) hold_req = 1'b1;
         put_fragment();
      end
      quiet_tail = 1'b1;
      byte_count = 0;
      while (byte_count < 150) put_fragment();
      put(pct_pkg::CH_NUL);
      req_bus.valid = 1'b0;

      while (expected_tokens.size() != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("pseudo_code_tokenizer_top test passed");
      end else begin
         $display("pseudo_code_tokenizer_top test failed");
      end
      $finish;
   end

   initial begin
      #500_000;
      $display("pseudo_code_tokenizer_top test failed");
      $finish;
   end

endmodule

// File: pseudo_code_tokenizer_top.f
hw/rtl/pct_pkg.sv
hw/rtl/pct_if.sv
hw/rtl/pct_front.sv
hw/rtl/pct_queue.sv
hw/rtl/pct_back.sv
hw/rtl/pseudo_code_tokenizer_top.sv
tb/pseudo_code_tokenizer_top_tb.sv
